// ===== rtl/ptbl_pkg.sv =====
// ----------------------------------------------------------------------------
// ptbl_pkg
// Shared types and constants for the per-client token bucket limiter.
// ----------------------------------------------------------------------------
package ptbl_pkg;

  localparam int NUM_CLIENTS = 64;
  localparam int SLOT_W      = 6;
  localparam int TIME_W      = 48;
  localparam int TOKEN_W     = 20;
  localparam int PERIOD_W    = 16;
  localparam int BURST_W     = 4;
  localparam int ADDR_W      = $clog2(NUM_CLIENTS);

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_REFILL_PERIOD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BURST_TOKENS  = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5000;
  localparam logic [BURST_W-1:0]  BURST_RESET  = 4'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] client_slot;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic [TOKEN_W-1:0] tokens_left;
  } rsp_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] tokens;
    logic [TIME_W-1:0]  last_refill;
  } bucket_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    bucket_t           data;
  } bucket_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DONE
  } state_t;

endpackage

// ===== rtl/ptbl_bucket_store.sv =====
// ----------------------------------------------------------------------------
// ptbl_bucket_store
// Bucket table: one synchronous read port, one write port, per-entry valid
// bits so that an entry never written reads as an empty, unused bucket.
// ----------------------------------------------------------------------------
module ptbl_bucket_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [ptbl_pkg::ADDR_W-1:0]   rd_addr,
  output ptbl_pkg::bucket_t             rd_bucket,
  input  ptbl_pkg::bucket_wr_t          wr
);
  import ptbl_pkg::*;

  bucket_t                mem [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] entry_valid;
  bucket_t                rd_raw;
  logic                   rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= entry_valid[rd_addr];
      end
    end
  end

  assign rd_bucket = rd_hit ? rd_raw : '0;

endmodule

// ===== rtl/per_client_token_bucket_limiter.sv =====
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter
// Token bucket per client slot, kept in a table and updated by
// read-modify-write for each request.
// The response is registered once the done state finds the output free.
// Requests are stalled outside idle: each one is read, computed in two steps
// and its bucket table entry written back before the next request is taken.
// Reset: table valid bits clear at once (every bucket reads as unused),
// refill period 5000, burst 3; no clearing pass.
// ----------------------------------------------------------------------------
module per_client_token_bucket_limiter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ptbl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptbl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  ptbl_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output ptbl_pkg::rsp_t                    rsp
);
  import ptbl_pkg::*;

  logic [PERIOD_W-1:0] refill_period_ms;
  logic [BURST_W-1:0]  burst_tokens;
  logic [PERIOD_W-1:0] unit;
  logic [TOKEN_W-1:0]  cap;

  state_t state;
  state_t state_next;

  logic                req_accept;
  logic                rsp_free;
  logic                rd_en;
  logic                finish;
  bucket_t             rd_bucket;
  bucket_wr_t          wr;

  logic [ADDR_W-1:0]   addr_q;
  logic                in_range_q;
  logic [TIME_W-1:0]   now_q;
  logic                fresh_q;
  logic                later_q;
  logic [TIME_W-1:0]   delta_q;
  logic [TOKEN_W-1:0]  tok_q;
  logic [TIME_W-1:0]   last_q;
  logic [TOKEN_W-1:0]  refill_q;

  logic                fresh;
  logic                later;
  logic [TIME_W:0]     sum;
  logic [TOKEN_W-1:0]  clamped;
  logic [TOKEN_W-1:0]  refill;
  logic                allow;
  logic [TOKEN_W-1:0]  left;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_period_ms <= PERIOD_RESET;
      burst_tokens     <= BURST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REFILL_PERIOD: refill_period_ms <= cfg_data;
        CFG_BURST_TOKENS:  burst_tokens     <= cfg_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  assign unit = (refill_period_ms == '0) ? PERIOD_W'(1) : refill_period_ms;
  assign cap  = TOKEN_W'({4'b0, unit} * {16'b0, burst_tokens});

  // control
  assign req_accept = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) state_next = S_READ;
      S_READ: state_next = S_CALC;
      S_CALC: state_next = S_DONE;
      S_DONE: if (rsp_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    finish    = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        rd_en     = req_valid;
      end
      S_DONE: finish = rsp_free;
      default: ;
    endcase
  end

  ptbl_bucket_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (req.client_slot[ADDR_W-1:0]),
    .rd_bucket (rd_bucket),
    .wr        (wr)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (req_accept) begin
      addr_q     <= req.client_slot[ADDR_W-1:0];
      in_range_q <= (int'(req.client_slot) < NUM_CLIENTS);
      now_q      <= req.now_ms;
    end
  end

  // step 1: compare times
  assign fresh = (rd_bucket.last_refill == '0);
  assign later = (now_q > rd_bucket.last_refill);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      fresh_q <= fresh;
      later_q <= later;
      delta_q <= now_q - rd_bucket.last_refill;
      tok_q   <= rd_bucket.tokens;
      last_q  <= (fresh || later) ? now_q : rd_bucket.last_refill;
    end
  end

  // step 2: refill and cap
  assign sum     = {{(TIME_W + 1 - TOKEN_W){1'b0}}, tok_q} + {1'b0, delta_q};
  assign clamped = (sum < {{(TIME_W + 1 - TOKEN_W){1'b0}}, cap}) ?
                   sum[TOKEN_W-1:0] : cap;

  always_comb begin
    if (fresh_q) begin
      refill = cap;
    end else if (later_q) begin
      refill = clamped;
    end else begin
      refill = tok_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      refill_q <= refill;
    end
  end

  // step 3: take a token, write back
  assign allow = (refill_q >= {4'b0, unit});
  assign left  = allow ? (refill_q - {4'b0, unit}) : refill_q;

  assign wr.en               = finish && in_range_q;
  assign wr.addr             = addr_q;
  assign wr.data.tokens      = left;
  assign wr.data.last_refill = last_q;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.allowed     <= in_range_q && allow;
      rsp.tokens_left <= in_range_q ? left : '0;
    end
  end

endmodule
